// ===== rtl/clx_pkg.sv =====
// Shared types, character constants and helper functions for the C syntax class lexer.
// It has no dependencies. The lexer, output buffer and top-level modules import it.
package clx_pkg;

  // Lexer modes.
  typedef enum logic [2:0] {
    MODE_NORMAL     = 3'd0,
    MODE_STR        = 3'd1,
    MODE_STR_ESC    = 3'd2,
    MODE_BLOCK      = 3'd3,
    MODE_BLOCK_STAR = 3'd4,
    MODE_LINE       = 3'd5
  } lex_mode_t;

  // Color classes carried on the result channel.
  localparam logic [2:0] CLS_PLAIN = 3'd0;
  localparam logic [2:0] CLS_NUM   = 3'd1;
  localparam logic [2:0] CLS_STR   = 3'd2;
  localparam logic [2:0] CLS_BLOCK = 3'd3;
  localparam logic [2:0] CLS_LINE  = 3'd4;

  // Characters that the lexer recognizes.
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // One result item.
  typedef struct packed {
    logic [7:0] ch;
    logic [2:0] cls;
    logic       marker;
    logic       last;
  } clx_res_t;

  // Results produced by one input item: up to two, in order.
  typedef struct packed {
    clx_res_t   res0;
    clx_res_t   res1;
    logic [1:0] num;
  } clx_step_t;

  // Outcome of classifying one byte in normal mode.
  typedef struct packed {
    logic       held;
    logic [2:0] cls;
    lex_mode_t  mode;
  } clx_nb_t;

  function automatic clx_res_t mk_res(logic [7:0] ch, logic [2:0] cls, logic marker,
                                      logic last);
    clx_res_t r;
    r.ch     = ch;
    r.cls    = cls;
    r.marker = marker;
    r.last   = last;
    return r;
  endfunction

  // Class of the construct that is open in a given mode.
  function automatic logic [2:0] mode_class(lex_mode_t m);
    logic [2:0] c;
    unique case (m) inside
      MODE_STR, MODE_STR_ESC:     c = CLS_STR;
      MODE_BLOCK, MODE_BLOCK_STAR: c = CLS_BLOCK;
      MODE_LINE:                  c = CLS_LINE;
      default:                    c = CLS_PLAIN;
    endcase
    return c;
  endfunction

  // Normal mode: a slash is held back, a digit is a number, a quote opens a string.
  function automatic clx_nb_t normal_byte(logic [7:0] ch);
    clx_nb_t nb;
    nb.held = 1'b0;
    nb.cls  = CLS_PLAIN;
    nb.mode = MODE_NORMAL;
    if (ch == CH_SLASH) begin
      nb.held = 1'b1;
    end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
      nb.cls = CLS_NUM;
    end else if (ch == CH_QUOTE) begin
      nb.cls  = CLS_STR;
      nb.mode = MODE_STR;
    end
    return nb;
  endfunction

endpackage

// ===== rtl/clx_lexer.sv =====
// Lexer state registers and the one-step classification logic.
// It depends on clx_pkg. The state advances only when the top level passes the item on.
module clx_lexer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        ch,
  input  logic              eol,
  input  logic              advance,
  output clx_pkg::clx_step_t step
);
  import clx_pkg::*;

  lex_mode_t mode_r, mode_nxt;
  logic      pend_r, pend_nxt;
  clx_nb_t   nb;

  // Classify the current item against the current mode.
  always_comb begin
    nb         = normal_byte(ch);
    step.res0  = mk_res(ch, CLS_PLAIN, 1'b0, 1'b0);
    step.res1  = mk_res(ch, CLS_PLAIN, 1'b0, 1'b0);
    step.num   = 2'd0;
    mode_nxt   = mode_r;
    pend_nxt   = pend_r;
    if (eol) begin
      // A held slash goes out as plain text ahead of the line marker.
      pend_nxt = 1'b0;
      if (pend_r) begin
        step.res0 = mk_res(CH_SLASH, CLS_PLAIN, 1'b0, 1'b0);
        step.res1 = mk_res(CH_NL, mode_class(mode_r), 1'b1, 1'b1);
        step.num  = 2'd2;
      end else begin
        step.res0 = mk_res(CH_NL, mode_class(mode_r), 1'b1, 1'b1);
        step.num  = 2'd1;
      end
      unique case (mode_r) inside
        MODE_STR, MODE_STR_ESC:      mode_nxt = MODE_STR;
        MODE_BLOCK, MODE_BLOCK_STAR: mode_nxt = MODE_BLOCK;
        default:                     mode_nxt = MODE_NORMAL;
      endcase
    end else if (pend_r) begin
      // The byte after a held slash decides what the slash opened.
      pend_nxt = 1'b0;
      if (ch == CH_STAR) begin
        step.res0 = mk_res(CH_SLASH, CLS_BLOCK, 1'b0, 1'b0);
        step.res1 = mk_res(ch, CLS_BLOCK, 1'b0, 1'b1);
        step.num  = 2'd2;
        mode_nxt  = MODE_BLOCK;
      end else if (ch == CH_SLASH) begin
        step.res0 = mk_res(CH_SLASH, CLS_LINE, 1'b0, 1'b0);
        step.res1 = mk_res(ch, CLS_LINE, 1'b0, 1'b1);
        step.num  = 2'd2;
        mode_nxt  = MODE_LINE;
      end else begin
        step.res0 = mk_res(CH_SLASH, CLS_PLAIN, 1'b0, 1'b1);
        step.num  = 2'd1;
        mode_nxt  = nb.mode;
        if (!nb.held) begin
          step.res0.last = 1'b0;
          step.res1      = mk_res(ch, nb.cls, 1'b0, 1'b1);
          step.num       = 2'd2;
        end
      end
    end else begin
      unique case (mode_r)
        MODE_STR: begin
          if (ch == CH_QUOTE) begin
            mode_nxt = MODE_NORMAL;
          end else if (ch == CH_BSLASH) begin
            mode_nxt = MODE_STR_ESC;
          end
          step.res0 = mk_res(ch, CLS_STR, 1'b0, 1'b1);
          step.num  = 2'd1;
        end
        MODE_STR_ESC: begin
          mode_nxt  = MODE_STR;
          step.res0 = mk_res(ch, CLS_STR, 1'b0, 1'b1);
          step.num  = 2'd1;
        end
        MODE_BLOCK: begin
          if (ch == CH_STAR) begin
            mode_nxt = MODE_BLOCK_STAR;
          end
          step.res0 = mk_res(ch, CLS_BLOCK, 1'b0, 1'b1);
          step.num  = 2'd1;
        end
        MODE_BLOCK_STAR: begin
          if (ch == CH_SLASH) begin
            mode_nxt = MODE_NORMAL;
          end else if (ch != CH_STAR) begin
            mode_nxt = MODE_BLOCK;
          end
          step.res0 = mk_res(ch, CLS_BLOCK, 1'b0, 1'b1);
          step.num  = 2'd1;
        end
        MODE_LINE: begin
          step.res0 = mk_res(ch, CLS_LINE, 1'b0, 1'b1);
          step.num  = 2'd1;
        end
        default: begin
          mode_nxt = nb.mode;
          if (nb.held) begin
            pend_nxt = 1'b1;
          end else begin
            step.res0 = mk_res(ch, nb.cls, 1'b0, 1'b1);
            step.num  = 2'd1;
          end
        end
      endcase
    end
  end

  // Mode and held-slash registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      pend_r <= 1'b0;
    end else if (advance) begin
      mode_r <= mode_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

// ===== rtl/clx_outbuf.sv =====
// Two-slot result register; it shows one result per cycle unless out_stall holds it.
// It depends on clx_pkg. A step with two results fills both slots at once.
module clx_outbuf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  clx_pkg::clx_step_t step,
  output logic               can_load,
  output logic               out_valid,
  input  logic               out_stall,
  output clx_pkg::clx_res_t  out_res
);
  import clx_pkg::*;

  logic [1:0] cnt_r, cnt_nxt;
  clx_res_t   slot0_r, slot0_nxt;
  clx_res_t   slot1_r, slot1_nxt;
  logic       out_fire;

  assign out_valid = (cnt_r != 2'd0);
  assign out_res   = slot0_r;
  assign out_fire  = out_valid && !out_stall;
  // Room for a whole new step: empty, or the only result leaves in this cycle.
  assign can_load  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_fire);

  // Next contents of the slots.
  always_comb begin
    cnt_nxt   = cnt_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    if (load) begin
      cnt_nxt   = step.num;
      slot0_nxt = step.res0;
      slot1_nxt = step.res1;
    end else if (out_fire) begin
      cnt_nxt   = cnt_r - 2'd1;
      slot0_nxt = slot1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  // The slot count never exceeds two.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result slot count out of range");

  // With two results waiting, the one shown first is never the last of its step.
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> !slot0_r.last)
    else $error("first result of a pair marked last");

endmodule

// ===== rtl/c_syntax_class_lexer_core.sv =====
// Top level of the C syntax class lexer: input register, lexer and result buffer.
// It depends on clx_pkg, clx_lexer and clx_outbuf.
//
// Usage:
//   The input channel (in_valid, in_stall, in_ch, in_is_line_end) takes one source
//   byte or one line-end marker per transfer. The result channel (out_valid,
//   out_stall, out_ch, out_color_class, out_line_marker, out_last) gives each byte
//   tagged 0 plain, 1 number, 2 string, 3 block comment or 4 line comment, plus a
//   newline result for every line end. An item gives zero, one or two results;
//   out_last marks the final one of an item. A slash is held back until the next
//   item shows what it opens, so it appears together with that next item.
//   Timing: an accepted item is registered, classified when the result buffer has
//   room, and its results are registered in that buffer before they are shown.
//   Throughput: one item per cycle while items give one result each and the
//   receiver does not stall; an item with two results holds the input back, since
//   the result channel moves one result per cycle.
//   Reset (rst_n low, synchronous) empties both registers and returns the lexer to
//   normal mode with no slash held. When the receiver stalls, the shown result
//   holds, the input register fills, and in_stall rises.
module c_syntax_class_lexer_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ch,
  input  logic       in_is_line_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_ch,
  output logic [2:0] out_color_class,
  output logic       out_line_marker,
  output logic       out_last
);
  import clx_pkg::*;

  logic       full_r, full_nxt;
  logic [7:0] ch_r;
  logic       eol_r;
  logic       can_load;
  logic       load;
  logic       in_fire;
  clx_step_t  step;
  clx_res_t   res;

  // The input register passes its item on whenever the result buffer has room.
  assign load     = full_r && can_load;
  assign in_stall = full_r && !can_load;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    full_nxt = full_r;
    if (in_fire) begin
      full_nxt = 1'b1;
    end else if (load) begin
      full_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ch_r  <= in_ch;
      eol_r <= in_is_line_end;
    end
  end

  clx_lexer u_lexer (
    .clk     (clk),
    .rst_n   (rst_n),
    .ch      (ch_r),
    .eol     (eol_r),
    .advance (load),
    .step    (step)
  );

  clx_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .step      (step),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_ch          = res.ch;
  assign out_color_class = res.cls;
  assign out_line_marker = res.marker;
  assign out_last        = res.last;

  // A line marker is always a newline and always ends its item.
  a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_line_marker) |-> (out_ch == CH_NL && out_last))
    else $error("malformed line marker result");

  // The class code stays within the five defined classes.
  a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_color_class <= CLS_LINE))
    else $error("color class out of range");

  // The second result of a pair follows right after the first one is taken.
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |=> out_valid)
    else $error("second result of a pair missing");

endmodule
